/* rtl/core/vtxp_pkg.sv */
package vtxp_pkg;

    // fixed point format of points, coefficients and results
    localparam int FRAC_BITS  = 16;
    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_W     = 64;
    localparam int CIDX_W     = 8;
    localparam int MAG_W      = 64;
    localparam int SUM_W      = 66;
    localparam int DIV_STEPS  = 32;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // sideband that rides along the divider pipeline
    typedef struct packed {
        logic wz;     // homogeneous w was zero
        logic nz;     // numerator nonzero
        logic nneg;   // numerator negative
        logic qneg;   // quotient negative
    } t_div_tag;

endpackage

/* rtl/core/vertex_project_unit.sv */
// A start passes the product, sum, magnitude, divider and output registers.
// Throughput: one point per cycle; busy stays low, a word can start every cycle.
// Depth is set by the 32-stage restoring divider, one quotient bit per stage.
// Reset (synchronous, active low) loads the identity matrix and empties the pipe.
// The receiver cannot stall: each result shows for exactly one cycle.
module vertex_project_unit
    import vtxp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [PAIR_W-1:0]   i_cfg_data,
    output logic                o_strobe,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic                o_w_zero,
    output logic                o_overflowed
);

    logic [PAIR_W-1:0] r_pair [0:NUM_PAIRS-1];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // coefficient registers, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair[0] <= 64'd65536;
            r_pair[1] <= '0;
            r_pair[2] <= 64'd65536 << 32;
            r_pair[3] <= '0;
            r_pair[4] <= '0;
            r_pair[5] <= 64'd65536;
            r_pair[6] <= '0;
            r_pair[7] <= 64'd65536 << 32;
        end else if (i_cfg_valid && (i_cfg_index < CIDX_W'(NUM_PAIRS))) begin
            r_pair[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    logic signed [31:0] m [0:15];
    for (genvar e = 0; e < 16; e++) begin : g_elem
        assign m[e] = r_pair[e/2][(e%2)*32 +: 32];
    end

    // stage 1: twelve products, plus the constant row
    logic               r_v1;
    logic signed [63:0] r_prod [0:3][0:2];
    logic signed [31:0] r_cst  [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        for (int c = 0; c < 4; c++) begin
            r_prod[c][0] <= i_in_x * m[c];
            r_prod[c][1] <= i_in_y * m[4+c];
            r_prod[c][2] <= i_in_z * m[8+c];
            r_cst[c]     <= m[12+c];
        end
    end

    // stage 2: exact column sums
    logic               r_v2;
    logic signed [SUM_W-1:0] r_sum [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        for (int c = 0; c < 4; c++) begin
            r_sum[c] <= SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1])
                      + SUM_W'(r_prod[c][2])
                      + (SUM_W'(r_cst[c]) <<< FRAC_BITS);
        end
    end

    // stage 3: sign and magnitude
    logic             r_v3;
    logic [MAG_W-1:0] r_mag [0:3];
    logic             r_neg [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int c = 0; c < 4; c++) begin
            r_neg[c] <= r_sum[c][SUM_W-1];
            r_mag[c] <= r_sum[c][SUM_W-1] ? MAG_W'(-r_sum[c]) : r_sum[c][MAG_W-1:0];
        end
    end

    // three dividers share the w magnitude
    logic        d_valid [0:2];
    logic [31:0] d_quot  [0:2];
    logic        d_big   [0:2];
    t_div_tag    d_tag   [0:2];
    t_div_tag    n_tag   [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_div
        assign n_tag[c].wz   = (r_mag[3] == '0);
        assign n_tag[c].nz   = (r_mag[c] != '0);
        assign n_tag[c].nneg = r_neg[c];
        assign n_tag[c].qneg = (r_neg[c] != r_neg[3]) && (r_mag[c] != '0);

        vtxp_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v3),
            .i_num   (r_mag[c]),
            .i_den   (r_mag[3]),
            .i_tag   (n_tag[c]),
            .o_valid (d_valid[c]),
            .o_quot  (d_quot[c]),
            .o_big   (d_big[c]),
            .o_tag   (d_tag[c])
        );
    end

    // final stage: saturation and flags
    logic [31:0] n_val [0:2];
    logic        n_ovf [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ovf[c] = 1'b0;
            if (d_tag[c].wz) begin
                n_val[c] = d_tag[c].nz ? (d_tag[c].nneg ? SAT_NEG : SAT_POS) : '0;
            end else if (d_big[c]) begin
                n_ovf[c] = 1'b1;
                n_val[c] = d_tag[c].qneg ? SAT_NEG : SAT_POS;
            end else if (!d_tag[c].qneg) begin
                n_ovf[c] = d_quot[c] > SAT_POS;
                n_val[c] = n_ovf[c] ? SAT_POS : d_quot[c];
            end else begin
                n_ovf[c] = d_quot[c] > SAT_NEG;
                n_val[c] = n_ovf[c] ? SAT_NEG : (32'd0 - d_quot[c]);
            end
        end
    end

    logic r_strobe;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic r_wz, r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d_valid[0];
        end
        r_ox  <= n_val[0];
        r_oy  <= n_val[1];
        r_oz  <= n_val[2];
        r_wz  <= d_tag[0].wz;
        r_ovf <= n_ovf[0] | n_ovf[1] | n_ovf[2];
    end

    assign o_strobe     = r_strobe;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_z      = r_oz;
    assign o_w_zero     = r_wz;
    assign o_overflowed = r_ovf;

endmodule

/* rtl/core/vtxp_div.sv */
module vtxp_div
    import vtxp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [MAG_W-1:0]   i_num,
    input  logic [MAG_W-1:0]   i_den,
    input  t_div_tag           i_tag,
    output logic               o_valid,
    output logic [31:0]        o_quot,
    output logic               o_big,
    output t_div_tag           o_tag
);

    localparam int NW = MAG_W + FRAC_BITS;

    logic [NW-1:0] n_scaled;
    logic          n_big;

    logic             r_v    [0:DIV_STEPS];
    logic [MAG_W-1:0] r_rem  [0:DIV_STEPS];
    logic [31:0]      r_low  [0:DIV_STEPS];
    logic [31:0]      r_q    [0:DIV_STEPS];
    logic [MAG_W-1:0] r_den  [0:DIV_STEPS];
    logic             r_big  [0:DIV_STEPS];
    t_div_tag         r_tag  [0:DIV_STEPS];

    // quotient of 2^32 or more saturates; test it up front
    assign n_scaled = {i_num, {FRAC_BITS{1'b0}}};
    assign n_big    = {{(96-NW){1'b0}}, n_scaled} >= {i_den, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= {{(MAG_W-(NW-32)){1'b0}}, n_scaled[NW-1:32]};
        r_low[0] <= n_scaled[31:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_big[0] <= n_big;
        r_tag[0] <= i_tag;
    end

    // one restoring step per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [MAG_W:0] n_shift;
        logic [MAG_W:0] n_diff;
        logic           n_ge;

        assign n_shift = {r_rem[k], r_low[k][31]};
        assign n_diff  = n_shift - {1'b0, r_den[k]};
        assign n_ge    = n_shift >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1] <= n_ge ? n_diff[MAG_W-1:0] : n_shift[MAG_W-1:0];
            r_low[k+1] <= {r_low[k][30:0], 1'b0};
            r_q[k+1]   <= {r_q[k][30:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_big[k+1] <= r_big[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quot  = r_q[DIV_STEPS];
    assign o_big   = r_big[DIV_STEPS];
    assign o_tag   = r_tag[DIV_STEPS];

endmodule

/* test/vertex_project_unit_test.sv */
module vertex_project_unit_test
    import vtxp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYC = 45;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    typedef enum logic [1:0] {K_POINT, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind              kind;
        logic signed [31:0] x, y, z;
        logic [CIDX_W-1:0]  idx;
        logic [PAIR_W-1:0]  data;
        int                 idle;
    } t_word;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic               wz, ovf;
    } t_proj;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic signed [31:0]  i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [PAIR_W-1:0]   i_cfg_data = '0;
    logic                o_strobe;
    logic signed [31:0]  o_out_x, o_out_y, o_out_z;
    logic                o_w_zero, o_overflowed;

    vertex_project_unit uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // matrix mirror, identity after reset
    logic [PAIR_W-1:0] coef_mirror [NUM_PAIRS] = '{64'h1_0000, 64'h0, 64'h1_0000 << 32, 64'h0,
                                                   64'h0, 64'h1_0000, 64'h0, 64'h1_0000 << 32};
    t_word  pending [$];
    t_proj  proj_due [$];
    int     errors = 0;
    int     quiet = 0;
    bit     gen_done = 0;

    function automatic logic signed [67:0] elem_q(int e);
        logic [63:0] pr;
        pr = coef_mirror[e >> 1];
        return {{36{pr[(e & 1) * 32 + 31]}}, pr[(e & 1) * 32 +: 32]};
    endfunction

    // exact column dot product with the point (x, y, z, 1)
    function automatic logic signed [67:0] column_sum(int c, logic signed [31:0] x,
                                                      logic signed [31:0] y,
                                                      logic signed [31:0] z);
        logic signed [67:0] ex, ey, ez, s;
        ex = x;
        ey = y;
        ez = z;
        s = ex * elem_q(c) + ey * elem_q(4 + c) + ez * elem_q(8 + c)
            + (elem_q(12 + c) <<< FRAC_BITS);
        return s;
    endfunction

    function automatic t_proj project_point(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
        t_proj              r;
        logic signed [67:0] sw, sn;
        logic [63:0]        wm, nm;
        logic [79:0]        q;
        logic               wneg, nneg, neg;
        logic [31:0]        v [3];
        sw = column_sum(3, x, y, z);
        wneg = sw < 0;
        wm = wneg ? 64'(-sw) : 64'(sw);
        r.ovf = 1'b0;
        for (int c = 0; c < 3; c++) begin
            sn = column_sum(c, x, y, z);
            nneg = sn < 0;
            nm = nneg ? 64'(-sn) : 64'(sn);
            if (wm == 0) begin
                v[c] = (nm == 0) ? 32'h0 : (nneg ? SAT_NEG : SAT_POS);
            end else begin
                neg = (nneg != wneg) && nm != 0;
                q = ({16'h0, nm} << FRAC_BITS) / {16'h0, wm};
                if (q[79:32] != 0 || (!neg && q > 80'h7FFF_FFFF) || (neg && q > 80'h8000_0000)) begin
                    r.ovf = 1'b1;
                    v[c] = neg ? SAT_NEG : SAT_POS;
                end else begin
                    v[c] = neg ? -q[31:0] : q[31:0];
                end
            end
        end
        r.px = v[0];
        r.py = v[1];
        r.pz = v[2];
        r.wz = (wm == 0);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // driver: one word at a time, config only when the pipe is empty
    always @(posedge i_clk) begin
        logic  nx_start, nx_cv;
        t_word w;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nx_start = i_start;
            nx_cv = i_cfg_valid;
            if (i_start && !o_busy) begin
                proj_due.push_back(project_point(i_in_x, i_in_y, i_in_z));
                nx_start = 1'b0;
                quiet = 0;
            end else if (quiet < 1000) begin
                quiet++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < NUM_PAIRS)
                    coef_mirror[i_cfg_index[2:0]] = i_cfg_data;
                nx_cv = 1'b0;
            end
            if (!nx_start && !nx_cv && pending.size() > 0) begin
                w = pending[0];
                case (w.kind)
                    K_POINT: if ($urandom_range(99, 0) >= w.idle) begin
                        void'(pending.pop_front());
                        nx_start = 1'b1;
                        i_in_x <= w.x;
                        i_in_y <= w.y;
                        i_in_z <= w.z;
                    end
                    K_CFG: if (proj_due.size() == 0 && quiet >= DRAIN_CYC) begin
                        void'(pending.pop_front());
                        nx_cv = 1'b1;
                        i_cfg_index <= w.idx;
                        i_cfg_data <= w.data;
                    end
                    default: if (proj_due.size() == 0)
                        void'(pending.pop_front());
                endcase
            end
            i_start <= nx_start;
            i_cfg_valid <= nx_cv;
        end
    end

    // monitor: compare each strobed word with the oldest prediction
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_strobe) begin
            if (proj_due.size() == 0) begin
                errors++;
                $display("unexpected result word at %0t", $realtime);
            end else begin
                e = proj_due.pop_front();
                if (o_out_x !== e.px) flag_mismatch("out_x", o_out_x, e.px);
                if (o_out_y !== e.py) flag_mismatch("out_y", o_out_y, e.py);
                if (o_out_z !== e.pz) flag_mismatch("out_z", o_out_z, e.pz);
                if (o_w_zero !== e.wz) flag_mismatch("w_zero", o_w_zero, e.wz);
                if (o_overflowed !== e.ovf) flag_mismatch("overflowed", o_overflowed, e.ovf);
            end
        end
    end

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, int idle);
        t_word w;
        w = '{kind: K_POINT, x: x, y: y, z: z, idx: '0, data: '0, idle: idle};
        pending.push_back(w);
    endtask

    task automatic add_cfg(int idx, logic [63:0] data);
        t_word w;
        w = '{kind: K_CFG, x: '0, y: '0, z: '0, idx: CIDX_W'(idx), data: data, idle: 0};
        pending.push_back(w);
    endtask

    task automatic add_drain();
        t_word w;
        w = '{kind: K_DRAIN, x: '0, y: '0, z: '0, idx: '0, data: '0, idle: 0};
        pending.push_back(w);
    endtask

    task automatic load_identity();
        add_cfg(0, {32'h0, ONE_Q});
        add_cfg(1, 64'h0);
        add_cfg(2, {ONE_Q, 32'h0});
        add_cfg(3, 64'h0);
        add_cfg(4, 64'h0);
        add_cfg(5, {32'h0, ONE_Q});
        add_cfg(6, 64'h0);
        add_cfg(7, {ONE_Q, 32'h0});
    endtask

    // mix of full range, small, exact and extreme values
    function automatic logic [31:0] rand_q(bit tame);
        case ($urandom_range(tame ? 3 : 6, 0))
            0: return $urandom_range(8 * 65536, 0) - 4 * 65536;
            1: return $urandom_range(3, 0) == 0 ? 32'h0 : ONE_Q;
            2: return $urandom_range(1024, 0) - 512;
            3: return $urandom_range(40 * 65536, 0) - 20 * 65536;
            4: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_matrix();
        logic [31:0] lo, hi;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            lo = rand_q($urandom_range(3, 0) != 0);
            hi = rand_q($urandom_range(3, 0) != 0);
            // keep w mostly away from zero so quotients stay in range
            if (k == 7 && $urandom_range(4, 0) != 0)
                hi = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            add_cfg(k, {hi, lo});
        end
    endtask

    initial begin
        int idle;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity with extreme points
        add_point(0, 0, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        add_point(32'h1_8000, 32'hFFFE_8000, 32'h0, 0);
        // tiny w: quotients overflow
        add_cfg(7, {32'h1, 32'h0});
        add_point(32'h1_0000, 32'hFFFF_0000, 0, 0);
        add_point(1, 32'hFFFF_FFFF, 0, 0);
        add_point(32'h7FFF, 32'hFFFF_8001, 32'h8000_0000, 0);
        // negative w
        add_cfg(7, {32'hFFFF_0000, 32'h0});
        add_point(32'h3_0000, 32'hFFFD_0000, 32'h0, 0);
        add_point(32'h8000_0000, 5, 32'h7FFF_FFFF, 0);
        // w exactly zero: positive, negative and zero numerators
        add_cfg(7, 64'h0);
        add_point(32'h1_0000, 32'hFFFF_0000, 0, 0);
        add_point(0, 0, 0, 0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        // out-of-range register indexes are dropped
        add_cfg(NUM_PAIRS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(255, 64'h8000_0000_8000_0000);
        add_point(32'h2_0000, 32'h3_0000, 32'h4_0000, 0);
        load_identity();
        add_point(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0001, 0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        // random phases: sender idle 22%, then 61%, then none
        for (int ph = 0; ph < 3; ph++) begin
            idle = (ph == 0) ? 22 : (ph == 1) ? 61 : 0;
            for (int m = 0; m < 4; m++) begin
                random_matrix();
                for (int n = 0; n < 70; n++) begin
                    if ($urandom_range(3, 0) == 0)
                        add_point($urandom, $urandom, $urandom, idle);
                    else
                        add_point(rand_q(0), rand_q(0), rand_q(0), idle);
                    if (n == 35 && m == 1)
                        add_drain();
                end
            end
        end
        // extreme matrix settings at the end
        for (int k = 0; k < NUM_PAIRS; k++)
            add_cfg(k, 64'h8000_0000_8000_0000);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        for (int k = 0; k < NUM_PAIRS; k++)
            add_cfg(k, 64'h7FFF_FFFF_7FFF_FFFF);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        gen_done = 1;
    end

    // end of run
    initial begin
        wait (gen_done);
        do @(posedge i_clk);
        while (pending.size() != 0 || i_start || i_cfg_valid || proj_due.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (proj_due.size() != 0) begin
            errors++;
            $display("%0d results never arrived", proj_due.size());
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
